FILE: rtl/ufmg_pkg.sv
// ============================================================================
// ufmg_pkg
// Shared types for the union-find maze generator: phase codes, controller
// states, find modes and the command and status groups between the
// controller and the datapath.
// ============================================================================
package ufmg_pkg;

   // Configuration register indexes.
   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   // Generation phase held in the datapath.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_H,
      PH_V,
      PH_LAST,
      PH_CHOOSE,
      PH_EH,
      PH_EV
   } phase_type;

   // Controller states.
   typedef enum logic [3:0] {
      CS_IDLE,
      CS_CLEAR,
      CS_STEP,
      CS_FLUSH,
      CS_WAIT,
      CS_FA,
      CS_PA,
      CS_FB,
      CS_PB,
      CS_ROOTS,
      CS_WALL,
      CS_EMIT,
      CS_DONE
   } ctl_state_type;

   // What a pair of finds is for.
   typedef enum logic [1:0] {
      FM_RIGHT,
      FM_VDOWN,
      FM_VFLAG,
      FM_EXTRA
   } fmode_type;

   // Source of the next walk pointer and of the parent read address.
   typedef enum logic [1:0] {
      X_HOLD,
      X_A,
      X_B,
      X_Q
   } xsel_type;

   typedef struct packed {
      logic      start;
      logic      bit_take;
      logic      bit_use;
      logic      sweep_en;
      logic      init_maze;
      logic      finish;
      logic      phase_we;
      phase_type phase_nxt;
      logic      row_one;
      logic      row_inc;
      logic      col_one;
      logic      col_inc;
      logic      flag_clr;
      logic      flag_set_eq;
      logic      extra_load;
      logic      extra_dec;
      xsel_type  x_sel;
      logic      b_down;
      logic      ra_cap;
      logic      rb_cap;
      logic      comp_wr;
      logic      comp_b;
      logic      join_wr;
      logic      wall_wr;
      logic      wall_down;
      logic      push;
      logic      res_down;
      logic      res_extra;
      logic      flush;
   } ufmg_cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      have;
      logic      rnd_bit;
      logic      flag;
      logic      col_ge_c;
      logic      col_gt_c;
      logic      row_lt_r;
      logic      row_gt_lim;
      logic      col_end;
      logic      half_zero;
      logic      extra_one;
      logic      q_is_x;
      logic      x_is_ra;
      logic      x_is_rb;
      logic      roots_eq;
      logic      wall_open;
      logic      pend_valid;
      logic      out_free;
      logic      emit_ok;
      logic      sweep_last;
   } ufmg_status_type;

endpackage

FILE: rtl/ufmg_ctrl.sv
// ============================================================================
// ufmg_ctrl
// Controller state machine: walks the generation phases, sequences the
// union-find walks, the wall checks and the result transfers.
// ============================================================================
module ufmg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ufmg_pkg::ufmg_status_type st,
   output ufmg_pkg::ufmg_cmd_type    cmd
);

   ufmg_pkg::ctl_state_type state_ff, state_in;
   ufmg_pkg::fmode_type     mode_ff, mode_in;

   // State and mode registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ufmg_pkg::CS_IDLE;
         mode_ff  <= ufmg_pkg::FM_RIGHT;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         ufmg_pkg::CS_IDLE: begin
            if (req_valid) state_in = ufmg_pkg::CS_CLEAR;
         end
         ufmg_pkg::CS_CLEAR: begin
            if (st.sweep_last) state_in = ufmg_pkg::CS_STEP;
         end
         ufmg_pkg::CS_STEP: begin
            unique case (st.phase)
               ufmg_pkg::PH_H: begin
                  if (!st.col_ge_c) begin
                     if (!st.have) state_in = ufmg_pkg::CS_FLUSH;
                     else if (st.rnd_bit) begin
                        mode_in  = ufmg_pkg::FM_RIGHT;
                        state_in = ufmg_pkg::CS_FA;
                     end
                  end
               end
               ufmg_pkg::PH_V: begin
                  if (!st.col_gt_c) begin
                     if (st.flag) begin
                        if (!st.have) state_in = ufmg_pkg::CS_FLUSH;
                        else begin
                           mode_in  = st.rnd_bit ? ufmg_pkg::FM_VDOWN : ufmg_pkg::FM_VFLAG;
                           state_in = ufmg_pkg::CS_FA;
                        end
                     end else begin
                        mode_in  = ufmg_pkg::FM_VDOWN;
                        state_in = ufmg_pkg::CS_FA;
                     end
                  end
               end
               ufmg_pkg::PH_LAST: begin
                  if (st.col_ge_c) begin
                     if (st.half_zero) state_in = ufmg_pkg::CS_DONE;
                  end else begin
                     mode_in  = ufmg_pkg::FM_RIGHT;
                     state_in = ufmg_pkg::CS_FA;
                  end
               end
               ufmg_pkg::PH_CHOOSE: begin
                  if (!st.have) state_in = ufmg_pkg::CS_FLUSH;
               end
               ufmg_pkg::PH_EH, ufmg_pkg::PH_EV: begin
                  if (!st.row_gt_lim && !st.col_end) begin
                     if (!st.have) state_in = ufmg_pkg::CS_FLUSH;
                     else if (st.rnd_bit) begin
                        mode_in  = ufmg_pkg::FM_EXTRA;
                        state_in = ufmg_pkg::CS_WALL;
                     end
                  end
               end
               default: state_in = ufmg_pkg::CS_IDLE;
            endcase
         end
         ufmg_pkg::CS_FLUSH: begin
            if (!st.pend_valid || st.out_free) state_in = ufmg_pkg::CS_WAIT;
         end
         ufmg_pkg::CS_WAIT: begin
            if (req_valid) state_in = ufmg_pkg::CS_STEP;
         end
         ufmg_pkg::CS_FA: begin
            if (st.q_is_x) state_in = ufmg_pkg::CS_PA;
         end
         ufmg_pkg::CS_PA: begin
            if (st.x_is_ra) state_in = ufmg_pkg::CS_FB;
         end
         ufmg_pkg::CS_FB: begin
            if (st.q_is_x) state_in = ufmg_pkg::CS_PB;
         end
         ufmg_pkg::CS_PB: begin
            if (st.x_is_rb) state_in = ufmg_pkg::CS_ROOTS;
         end
         ufmg_pkg::CS_ROOTS: begin
            unique case (mode_ff)
               ufmg_pkg::FM_RIGHT: begin
                  state_in = st.roots_eq ? ufmg_pkg::CS_STEP : ufmg_pkg::CS_EMIT;
               end
               ufmg_pkg::FM_VDOWN: begin
                  if (st.roots_eq) begin
                     mode_in  = ufmg_pkg::FM_VFLAG;
                     state_in = ufmg_pkg::CS_FA;
                  end else state_in = ufmg_pkg::CS_EMIT;
               end
               default: state_in = ufmg_pkg::CS_STEP;
            endcase
         end
         ufmg_pkg::CS_WALL: begin
            state_in = st.wall_open ? ufmg_pkg::CS_STEP : ufmg_pkg::CS_EMIT;
         end
         ufmg_pkg::CS_EMIT: begin
            if (st.emit_ok) begin
               unique case (mode_ff)
                  ufmg_pkg::FM_VDOWN: begin
                     mode_in  = ufmg_pkg::FM_VFLAG;
                     state_in = ufmg_pkg::CS_FA;
                  end
                  ufmg_pkg::FM_EXTRA: begin
                     state_in = st.extra_one ? ufmg_pkg::CS_DONE : ufmg_pkg::CS_STEP;
                  end
                  default: state_in = ufmg_pkg::CS_STEP;
               endcase
            end
         end
         ufmg_pkg::CS_DONE: begin
            if (st.out_free) state_in = ufmg_pkg::CS_IDLE;
         end
         default: state_in = ufmg_pkg::CS_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      cmd.b_down    = (mode_ff == ufmg_pkg::FM_VDOWN);
      cmd.res_down  = (mode_ff == ufmg_pkg::FM_VDOWN) ||
                      ((mode_ff == ufmg_pkg::FM_EXTRA) && (st.phase == ufmg_pkg::PH_EV));
      cmd.res_extra = (mode_ff == ufmg_pkg::FM_EXTRA);
      unique case (state_ff)
         ufmg_pkg::CS_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ufmg_pkg::CS_CLEAR: begin
            cmd.sweep_en  = 1'b1;
            cmd.init_maze = st.sweep_last;
         end
         ufmg_pkg::CS_STEP: begin
            unique case (st.phase)
               ufmg_pkg::PH_H: begin
                  if (st.col_ge_c) begin
                     cmd.col_one  = 1'b1;
                     cmd.phase_we = 1'b1;
                     cmd.flag_clr = 1'b1;
                     cmd.phase_nxt = st.row_lt_r ? ufmg_pkg::PH_V : ufmg_pkg::PH_LAST;
                  end else if (st.have) begin
                     cmd.bit_use = 1'b1;
                     if (st.rnd_bit) cmd.x_sel = ufmg_pkg::X_A;
                     else cmd.col_inc = 1'b1;
                  end
               end
               ufmg_pkg::PH_V: begin
                  if (st.col_gt_c) begin
                     cmd.phase_we  = 1'b1;
                     cmd.phase_nxt = ufmg_pkg::PH_H;
                     cmd.row_inc   = 1'b1;
                     cmd.col_one   = 1'b1;
                  end else if (st.flag) begin
                     if (st.have) begin
                        cmd.bit_use = 1'b1;
                        cmd.x_sel   = ufmg_pkg::X_A;
                     end
                  end else cmd.x_sel = ufmg_pkg::X_A;
               end
               ufmg_pkg::PH_LAST: begin
                  if (st.col_ge_c) begin
                     cmd.extra_load = 1'b1;
                     if (!st.half_zero) begin
                        cmd.phase_we  = 1'b1;
                        cmd.phase_nxt = ufmg_pkg::PH_CHOOSE;
                     end
                  end else cmd.x_sel = ufmg_pkg::X_A;
               end
               ufmg_pkg::PH_CHOOSE: begin
                  if (st.have) begin
                     cmd.bit_use   = 1'b1;
                     cmd.phase_we  = 1'b1;
                     cmd.phase_nxt = st.rnd_bit ? ufmg_pkg::PH_EH : ufmg_pkg::PH_EV;
                     cmd.row_one   = 1'b1;
                     cmd.col_one   = 1'b1;
                  end
               end
               ufmg_pkg::PH_EH, ufmg_pkg::PH_EV: begin
                  if (st.row_gt_lim) begin
                     cmd.phase_we  = 1'b1;
                     cmd.phase_nxt = ufmg_pkg::PH_CHOOSE;
                  end else if (st.col_end) begin
                     cmd.row_inc = 1'b1;
                     cmd.col_one = 1'b1;
                  end else if (st.have) begin
                     cmd.bit_use = 1'b1;
                     cmd.col_inc = !st.rnd_bit;
                  end
               end
               default: ;
            endcase
         end
         ufmg_pkg::CS_FLUSH: begin
            cmd.flush = st.pend_valid && st.out_free;
         end
         ufmg_pkg::CS_WAIT: begin
            req_stall    = 1'b0;
            cmd.bit_take = req_valid;
         end
         ufmg_pkg::CS_FA: begin
            if (st.q_is_x) begin
               cmd.ra_cap = 1'b1;
               cmd.x_sel  = ufmg_pkg::X_A;
            end else cmd.x_sel = ufmg_pkg::X_Q;
         end
         ufmg_pkg::CS_PA: begin
            if (st.x_is_ra) cmd.x_sel = ufmg_pkg::X_B;
            else begin
               cmd.comp_wr = 1'b1;
               cmd.x_sel   = ufmg_pkg::X_Q;
            end
         end
         ufmg_pkg::CS_FB: begin
            if (st.q_is_x) begin
               cmd.rb_cap = 1'b1;
               cmd.x_sel  = ufmg_pkg::X_B;
            end else cmd.x_sel = ufmg_pkg::X_Q;
         end
         ufmg_pkg::CS_PB: begin
            if (!st.x_is_rb) begin
               cmd.comp_wr = 1'b1;
               cmd.comp_b  = 1'b1;
               cmd.x_sel   = ufmg_pkg::X_Q;
            end
         end
         ufmg_pkg::CS_ROOTS: begin
            unique case (mode_ff)
               ufmg_pkg::FM_RIGHT: begin
                  if (!st.roots_eq) begin
                     cmd.join_wr = 1'b1;
                     cmd.wall_wr = 1'b1;
                  end else cmd.col_inc = 1'b1;
               end
               ufmg_pkg::FM_VDOWN: begin
                  if (!st.roots_eq) begin
                     cmd.join_wr   = 1'b1;
                     cmd.wall_wr   = 1'b1;
                     cmd.wall_down = 1'b1;
                  end else cmd.x_sel = ufmg_pkg::X_A;
               end
               ufmg_pkg::FM_VFLAG: begin
                  cmd.flag_set_eq = 1'b1;
                  cmd.col_inc     = 1'b1;
               end
               default: ;
            endcase
         end
         ufmg_pkg::CS_WALL: begin
            if (!st.wall_open) begin
               cmd.wall_wr   = 1'b1;
               cmd.wall_down = (st.phase == ufmg_pkg::PH_EV);
            end else cmd.col_inc = 1'b1;
         end
         ufmg_pkg::CS_EMIT: begin
            if (st.emit_ok) begin
               cmd.push = 1'b1;
               unique case (mode_ff)
                  ufmg_pkg::FM_VDOWN: cmd.x_sel = ufmg_pkg::X_A;
                  ufmg_pkg::FM_EXTRA: begin
                     cmd.extra_dec = 1'b1;
                     if (!st.extra_one) begin
                        cmd.phase_we  = 1'b1;
                        cmd.phase_nxt = ufmg_pkg::PH_CHOOSE;
                     end
                  end
                  default: cmd.col_inc = 1'b1;
               endcase
            end
         end
         ufmg_pkg::CS_DONE: begin
            cmd.finish = st.out_free;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/ufmg_datapath.sv
// ============================================================================
// ufmg_datapath
// Datapath: configuration registers, position counters, the parent memory
// with its walk pointer, the two wall bitmaps and the result registers.
// ============================================================================
module ufmg_datapath #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [5:0]                csr_write_data,
   input  logic                      req_random_bit,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [5:0]                rsp_cell_row,
   output logic [5:0]                rsp_cell_col,
   output logic                      rsp_toward_down,
   output logic                      rsp_extra_loop,
   output logic                      rsp_maze_done,
   output logic                      rsp_last,
   input  ufmg_pkg::ufmg_cmd_type    cmd,
   output ufmg_pkg::ufmg_status_type st
);

   localparam int RW     = $clog2(MAX_ROWS + 2);
   localparam int CW     = $clog2(MAX_COLS + 2);
   localparam int SWD    = CW + 1;
   localparam int DW     = (RW > CW) ? RW : CW;
   localparam int PDEPTH = (MAX_ROWS + 2) * (MAX_COLS + 2);
   localparam int PW     = $clog2(PDEPTH);
   localparam int WRB    = $clog2(MAX_ROWS);
   localparam int WCB    = $clog2(MAX_COLS);
   localparam int WAW    = WRB + WCB;
   localparam int WDEPTH = 2 ** WAW;
   localparam int SDEPTH = (PDEPTH > WDEPTH) ? PDEPTH : WDEPTH;
   localparam int SW     = $clog2(SDEPTH);

   // Configuration registers and latched maze sizes.
   logic [5:0]     row_cnt_ff, col_cnt_ff;
   logic [RW-1:0]  eff_rows_ff, rows_clamp;
   logic [CW-1:0]  eff_cols_ff, cols_clamp;
   logic [SWD-1:0] stride_ff;

   // Position and phase state.
   ufmg_pkg::phase_type phase_ff;
   logic [RW-1:0]  row_ff;
   logic [CW-1:0]  col_ff;
   logic           flag_ff;
   logic [DW-1:0]  extra_ff;
   logic           have_ff, bit_ff;
   logic [SW-1:0]  sweep_ff;

   // Union-find walk.
   logic [PW-1:0]  x_ff, x_in, ra_ff, rb_ff, parent_q_ff;
   logic [PW-1:0]  cell_a, cell_b;
   logic [PW-1:0]  par_wa, par_wd;
   logic           par_we;
   logic [PW-1:0]  parent_mem [PDEPTH];

   // Wall bitmaps.
   logic           right_mem [WDEPTH];
   logic           down_mem  [WDEPTH];
   logic           right_q_ff, down_q_ff;
   logic [WAW-1:0] widx, wall_wa;
   logic [RW-1:0]  row_m1;
   logic [CW-1:0]  col_m1;
   logic           right_we, down_we, wall_wd;
   logic           sweep_par, sweep_wall;

   // Result registers.
   logic           pend_valid_ff, out_valid_ff, out_take, out_load;
   logic [5:0]     pend_row_ff, pend_col_ff;
   logic           pend_down_ff, pend_extra_ff;
   logic [5:0]     out_row_ff, out_col_ff;
   logic           out_down_ff, out_extra_ff, out_done_ff, out_last_ff;
   logic [RW+5:0]  row_wide;
   logic [CW+5:0]  col_wide;
   logic [DW-1:0]  r_ext, c_ext, dim_min, half;

   // Register size clamping.
   always_comb begin
      if (row_cnt_ff == 6'd0) rows_clamp = RW'(1);
      else if (32'(row_cnt_ff) > MAX_ROWS) rows_clamp = RW'(MAX_ROWS);
      else rows_clamp = RW'(row_cnt_ff);
      if (col_cnt_ff == 6'd0) cols_clamp = CW'(1);
      else if (32'(col_cnt_ff) > MAX_COLS) cols_clamp = CW'(MAX_COLS);
      else cols_clamp = CW'(col_cnt_ff);
   end

   // Configuration writes and size latch at maze start.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= 6'd8;
         col_cnt_ff <= 6'd8;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ufmg_pkg::CSR_ROW_COUNT: row_cnt_ff <= csr_write_data;
            ufmg_pkg::CSR_COL_COUNT: col_cnt_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_rows_ff <= RW'(1);
         eff_cols_ff <= CW'(1);
         stride_ff   <= SWD'(3);
      end else if (cmd.start) begin
         eff_rows_ff <= rows_clamp;
         eff_cols_ff <= cols_clamp;
         stride_ff   <= SWD'(cols_clamp) + SWD'(2);
      end
   end

   // Number of extra walls: half the smaller side.
   always_comb begin
      r_ext   = DW'(eff_rows_ff);
      c_ext   = DW'(eff_cols_ff);
      dim_min = (r_ext < c_ext) ? r_ext : c_ext;
      half    = dim_min >> 1;
   end

   // Phase, position, flag and extra counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ufmg_pkg::PH_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         flag_ff  <= 1'b0;
         extra_ff <= '0;
      end else if (cmd.init_maze) begin
         phase_ff <= ufmg_pkg::PH_H;
         row_ff   <= RW'(1);
         col_ff   <= CW'(1);
         flag_ff  <= 1'b0;
         extra_ff <= '0;
      end else if (cmd.finish) begin
         phase_ff <= ufmg_pkg::PH_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         flag_ff  <= 1'b0;
      end else begin
         if (cmd.phase_we) phase_ff <= cmd.phase_nxt;
         if (cmd.row_one) row_ff <= RW'(1);
         else if (cmd.row_inc) row_ff <= row_ff + RW'(1);
         if (cmd.col_one) col_ff <= CW'(1);
         else if (cmd.col_inc) col_ff <= col_ff + CW'(1);
         if (cmd.flag_clr) flag_ff <= 1'b0;
         else if (cmd.flag_set_eq) flag_ff <= (ra_ff == rb_ff);
         if (cmd.extra_load) extra_ff <= half;
         else if (cmd.extra_dec) extra_ff <= extra_ff - DW'(1);
      end
   end

   // Random bit holding register.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.start || cmd.bit_take) begin
         have_ff <= 1'b1;
      end else if (cmd.bit_use) begin
         have_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start || cmd.bit_take) bit_ff <= req_random_bit;
   end

   // Clearing sweep counter.
   always_ff @(posedge clock) begin
      if (reset || cmd.start) sweep_ff <= '0;
      else if (cmd.sweep_en) sweep_ff <= sweep_ff + SW'(1);
   end

   assign sweep_par  = 32'(sweep_ff) < PDEPTH;
   assign sweep_wall = 32'(sweep_ff) < WDEPTH;

   // Cell indexes with a border of one cell around the grid.
   always_comb begin
      cell_a = PW'(row_ff) * PW'(stride_ff) + PW'(col_ff);
      cell_b = cell_a + (cmd.b_down ? PW'(stride_ff) : PW'(1));
   end

   // Walk pointer; the parent read follows the pointer's next value.
   always_comb begin
      unique case (cmd.x_sel)
         ufmg_pkg::X_A: x_in = cell_a;
         ufmg_pkg::X_B: x_in = cell_b;
         ufmg_pkg::X_Q: x_in = parent_q_ff;
         default:       x_in = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.ra_cap) ra_ff <= x_ff;
      if (cmd.rb_cap) rb_ff <= x_ff;
   end

   // Parent write port: clearing sweep, join of two roots, or compression.
   always_comb begin
      par_we = 1'b0;
      par_wa = x_ff;
      par_wd = ra_ff;
      priority if (cmd.sweep_en) begin
         par_we = sweep_par;
         par_wa = sweep_ff[PW-1:0];
         par_wd = sweep_ff[PW-1:0];
      end else if (cmd.join_wr) begin
         par_we = 1'b1;
         par_wa = rb_ff;
         par_wd = ra_ff;
      end else if (cmd.comp_wr) begin
         par_we = 1'b1;
         par_wa = x_ff;
         par_wd = cmd.comp_b ? rb_ff : ra_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (par_we) parent_mem[par_wa] <= par_wd;
      parent_q_ff <= parent_mem[x_in];
   end

   // Wall bitmaps, addressed by row and column of the current cell.
   always_comb begin
      row_m1  = row_ff - RW'(1);
      col_m1  = col_ff - CW'(1);
      widx    = {row_m1[WRB-1:0], col_m1[WCB-1:0]};
      wall_wa = cmd.sweep_en ? sweep_ff[WAW-1:0] : widx;
      wall_wd = !cmd.sweep_en;
      right_we = (cmd.sweep_en && sweep_wall) || (cmd.wall_wr && !cmd.wall_down);
      down_we  = (cmd.sweep_en && sweep_wall) || (cmd.wall_wr && cmd.wall_down);
   end

   always_ff @(posedge clock) begin
      if (right_we) right_mem[wall_wa] <= wall_wd;
      if (down_we) down_mem[wall_wa] <= wall_wd;
      right_q_ff <= right_mem[widx];
      down_q_ff  <= down_mem[widx];
   end

   // Result fields for the current cell.
   assign row_wide = {6'b0, row_ff};
   assign col_wide = {6'b0, col_ff};

   // The newest result waits in the pending register until it is known
   // whether another one follows from the same item.
   assign out_take = out_valid_ff && !rsp_stall;
   assign out_load = (cmd.push && pend_valid_ff) || (cmd.flush && pend_valid_ff) || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.push) pend_valid_ff <= 1'b1;
         else if (cmd.flush || cmd.finish) pend_valid_ff <= 1'b0;
         if (out_load) out_valid_ff <= 1'b1;
         else if (out_take) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pend_row_ff   <= row_wide[5:0];
         pend_col_ff   <= col_wide[5:0];
         pend_down_ff  <= cmd.res_down;
         pend_extra_ff <= cmd.res_extra;
      end
      if (out_load) begin
         out_row_ff   <= pend_valid_ff ? pend_row_ff : 6'd0;
         out_col_ff   <= pend_valid_ff ? pend_col_ff : 6'd0;
         out_down_ff  <= pend_valid_ff && pend_down_ff;
         out_extra_ff <= pend_valid_ff && pend_extra_ff;
         out_done_ff  <= cmd.finish;
         out_last_ff  <= cmd.flush || cmd.finish;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_cell_row    = out_row_ff;
   assign rsp_cell_col    = out_col_ff;
   assign rsp_toward_down = out_down_ff;
   assign rsp_extra_loop  = out_extra_ff;
   assign rsp_maze_done   = out_done_ff;
   assign rsp_last        = out_last_ff;

   // Status toward the controller.
   always_comb begin
      st.phase      = phase_ff;
      st.have       = have_ff;
      st.rnd_bit    = bit_ff;
      st.flag       = flag_ff;
      st.col_ge_c   = col_ff >= eff_cols_ff;
      st.col_gt_c   = col_ff > eff_cols_ff;
      st.row_lt_r   = row_ff < eff_rows_ff;
      st.row_gt_lim = (phase_ff == ufmg_pkg::PH_EH) ? (row_ff > eff_rows_ff)
                                                    : (row_ff >= eff_rows_ff);
      st.col_end    = (phase_ff == ufmg_pkg::PH_EH) ? (col_ff >= eff_cols_ff)
                                                    : (col_ff > eff_cols_ff);
      st.half_zero  = (half == '0);
      st.extra_one  = (extra_ff == DW'(1));
      st.q_is_x     = (parent_q_ff == x_ff);
      st.x_is_ra    = (x_ff == ra_ff);
      st.x_is_rb    = (x_ff == rb_ff);
      st.roots_eq   = (ra_ff == rb_ff);
      st.wall_open  = (phase_ff == ufmg_pkg::PH_EH) ? right_q_ff : down_q_ff;
      st.pend_valid = pend_valid_ff;
      st.out_free   = !out_valid_ff || !rsp_stall;
      st.emit_ok    = !pend_valid_ff || !out_valid_ff || !rsp_stall;
      st.sweep_last = (sweep_ff == SW'(SDEPTH - 1));
   end

endmodule

FILE: rtl/union_find_maze_generator.sv
// ============================================================================
// union_find_maze_generator
// Row-by-row maze generator over a union-find of grid cells. Each request
// transfer carries one random bit; each response transfer reports at most one
// opened wall.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   random_bit
//   rsp_      out        rsp_valid/rsp_stall   cell_row, cell_col, toward_down,
//                                              extra_loop, maze_done, last
//   csr_      in         csr_write_enable      csr_index, csr_write_data
//
// A bit passes through the accept, step and flush states, plus its wall checks.
// A union-find check walks each find and compression link by link and pushes a
// result if the roots differ; an extra-wall check reads one wall bitmap.
// Unflagged down walls and the last row use no bits, so one bit can check a
// whole row. A maze start first runs a clearing pass over the parent memory
// and both wall bitmaps. Reset is synchronous and needs no clearing pass; a
// stalled response holds while the block keeps working until a second result
// is waiting.
// ============================================================================
module union_find_maze_generator #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [5:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_random_bit,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_cell_row,
   output logic [5:0] rsp_cell_col,
   output logic       rsp_toward_down,
   output logic       rsp_extra_loop,
   output logic       rsp_maze_done,
   output logic       rsp_last
);

   ufmg_pkg::ufmg_cmd_type    cmd;
   ufmg_pkg::ufmg_status_type st;

   // Sequencing of phases, finds and result transfers.
   ufmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Memories, counters and result registers.
   ufmg_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_random_bit   (req_random_bit),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_cell_col     (rsp_cell_col),
      .rsp_toward_down  (rsp_toward_down),
      .rsp_extra_loop   (rsp_extra_loop),
      .rsp_maze_done    (rsp_maze_done),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .st               (st)
   );

endmodule
